[rtl/snsg_pkg.sv]
// ----------------------------------------------------------------------------
// snsg_pkg: shared types and constants
// Widths, reset values, the attenuation table and the channel state word of
// the square/noise sound generator.
// ----------------------------------------------------------------------------
package snsg_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanIdxWidth = 2;
  localparam int unsigned PeriodWidth = 10;
  localparam int unsigned AttenWidth = 4;
  localparam int unsigned LevelWidth = 8;
  localparam int unsigned NoiseWidth = 16;
  localparam int unsigned PhaseWidth = 16;
  localparam int unsigned TickIncWidth = 20;
  localparam int unsigned GainWidth = 7;
  localparam int unsigned TickCntWidth = 5;   // whole ticks per word, at most 16
  localparam int unsigned MixWidth = 11;      // four levels of +-255
  localparam int unsigned ProdWidth = 18;     // mix times gain
  localparam int unsigned SampleWidth = 16;

  localparam logic [ChanIdxWidth-1:0] NoiseChan = 2'd3;
  localparam logic [ChanIdxWidth-1:0] LastChan = 2'd3;

  localparam logic [TickIncWidth-1:0] TickIncReset = 20'd332467;
  localparam logic [GainWidth-1:0] GainReset = 7'd24;
  localparam logic [NoiseWidth-1:0] NoiseReset = 16'h8000;
  localparam logic [AttenWidth-1:0] AttenSilent = 4'd15;
  localparam logic [PeriodWidth-1:0] PeriodReset = 10'd1;

  localparam logic [ProdWidth-1:0] SatMax = 18'sd32767;
  localparam logic [ProdWidth-1:0] SatMin = -18'sd32768;

  // configuration register indexes
  localparam logic CfgTickInc = 1'b0;
  localparam logic CfgGain = 1'b1;

  // input kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindSample = 1'b1;

  typedef struct packed {
    logic [PeriodWidth-1:0] count;
    logic                   out_bit;
  } chan_state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic mul;
  } mix_ctrl_t;

  function automatic logic [LevelWidth-1:0] atten_level(input logic [AttenWidth-1:0] a);
    logic [LevelWidth-1:0] lv;
    unique case (a)
      4'd0:    lv = 8'd255;
      4'd1:    lv = 8'd202;
      4'd2:    lv = 8'd161;
      4'd3:    lv = 8'd128;
      4'd4:    lv = 8'd101;
      4'd5:    lv = 8'd81;
      4'd6:    lv = 8'd64;
      4'd7:    lv = 8'd51;
      4'd8:    lv = 8'd40;
      4'd9:    lv = 8'd32;
      4'd10:   lv = 8'd26;
      4'd11:   lv = 8'd20;
      4'd12:   lv = 8'd16;
      4'd13:   lv = 8'd13;
      4'd14:   lv = 8'd10;
      default: lv = 8'd0;
    endcase
    return lv;
  endfunction

endpackage

[rtl/snsg_tick_unit.sv]
// ----------------------------------------------------------------------------
// snsg_tick_unit: one channel step of a chip tick
// Counts the channel down, reloads it at zero and toggles the square output
// or shifts the noise register. Shared by all four channels in turn.
// ----------------------------------------------------------------------------
module snsg_tick_unit (
  input  snsg_pkg::chan_state_t               cur,
  input  logic [snsg_pkg::PeriodWidth-1:0]    period,
  input  logic                                is_noise,
  input  logic [snsg_pkg::NoiseWidth-1:0]     noise,
  output snsg_pkg::chan_state_t               nxt,
  output logic [snsg_pkg::NoiseWidth-1:0]     noise_next
);

  logic [snsg_pkg::PeriodWidth-1:0] dec;
  logic [snsg_pkg::PeriodWidth-1:0] reload;
  logic                             hit;
  logic                             fb;
  logic [snsg_pkg::NoiseWidth-1:0]  shifted;

  assign dec = (cur.count != '0) ? cur.count - 1'b1 : '0;
  assign hit = (dec == '0);
  assign reload = (period != '0) ? period : snsg_pkg::PeriodReset;

  // bit 2 of the noise period picks white feedback
  assign fb = period[2] ? (noise[0] ^ noise[3]) : noise[0];
  assign shifted = {fb, noise[snsg_pkg::NoiseWidth-1:1]};

  always_comb begin
    nxt.count = hit ? reload : dec;
    nxt.out_bit = cur.out_bit;
    noise_next = noise;
    if (hit) begin
      if (is_noise) begin
        noise_next = shifted;
        nxt.out_bit = shifted[0];
      end else begin
        nxt.out_bit = ~cur.out_bit;
      end
    end
  end

endmodule

[rtl/snsg_mix_unit.sv]
// ----------------------------------------------------------------------------
// snsg_mix_unit: channel mixer
// Accumulates +level or -level one channel a cycle, multiplies the sum by the
// gain into a product register and saturates to 16 bits.
// ----------------------------------------------------------------------------
module snsg_mix_unit (
  input  logic                                  clk,
  input  snsg_pkg::mix_ctrl_t                   ctrl,
  input  logic [snsg_pkg::LevelWidth-1:0]       level,
  input  logic                                  positive,
  input  logic [snsg_pkg::GainWidth-1:0]        gain,
  output logic signed [snsg_pkg::SampleWidth-1:0] sample
);

  logic signed [snsg_pkg::MixWidth-1:0]  mix;
  logic signed [snsg_pkg::MixWidth-1:0]  term;
  logic signed [snsg_pkg::ProdWidth-1:0] prod;
  logic signed [snsg_pkg::MixWidth+snsg_pkg::GainWidth:0] full;

  assign term = positive ? $signed({3'b000, level}) : -$signed({3'b000, level});
  assign full = mix * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      mix <= '0;
    end else if (ctrl.add) begin
      mix <= mix + term;
    end
    if (ctrl.mul) begin
      prod <= full[snsg_pkg::ProdWidth-1:0];
    end
  end

  always_comb begin
    if (prod > $signed(snsg_pkg::SatMax)) begin
      sample = 16'sh7FFF;
    end else if (prod < $signed(snsg_pkg::SatMin)) begin
      sample = 16'sh8000;
    end else begin
      sample = prod[snsg_pkg::SampleWidth-1:0];
    end
  end

endmodule

[rtl/square_noise_sound_generator_unit.sv]
// ----------------------------------------------------------------------------
// square_noise_sound_generator_unit: four-channel square/noise generator
// Three square channels and one noise channel, register-byte programmed,
// mixed to one saturated mono sample per sample word.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   kind, write_byte
//   out      source     out_valid/out_stall sample_value
//   cfg      sink       cfg_write           cfg_index, cfg_data
//
// A register-write word completes in the cycle it is accepted.
// A sample word runs T chip ticks (5 or 6 at the reset rate): the single tick
// unit visits one channel per cycle, then the mixer sums the four channels,
// multiplies the sum by the gain and the sample is loaded out.
// Reset is synchronous and restores all channel state and both registers.
// in_stall is high while a sample is in flight; a finished sample waits in
// that state until the output register is free.
// ----------------------------------------------------------------------------
module square_noise_sound_generator_unit (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      kind,
  input  logic [7:0]                                write_byte,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [snsg_pkg::SampleWidth-1:0]   sample_value,
  input  logic                                      cfg_write,
  input  logic                                      cfg_index,
  input  logic [snsg_pkg::TickIncWidth-1:0]         cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TICK = 5'b00010,
    S_MIX  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [snsg_pkg::TickIncWidth-1:0] tick_inc;
  logic [snsg_pkg::GainWidth-1:0]    gain;

  logic [snsg_pkg::PeriodWidth-1:0] tone_period [snsg_pkg::NumChannels];
  logic [snsg_pkg::PeriodWidth-1:0] tick_counter [snsg_pkg::NumChannels];
  logic [snsg_pkg::AttenWidth-1:0]  attenuation [snsg_pkg::NumChannels];
  logic [snsg_pkg::NumChannels-1:0] chan_out;
  logic [snsg_pkg::NoiseWidth-1:0]  noise_shift;
  logic [2:0]                       latched_target;
  logic [snsg_pkg::PhaseWidth-1:0]  phase;

  logic [snsg_pkg::ChanIdxWidth-1:0] ch;
  logic [snsg_pkg::TickCntWidth-1:0] ticks_left;

  logic                                in_take;
  logic                                out_free;
  logic [snsg_pkg::TickIncWidth:0]     phase_sum;
  logic [snsg_pkg::ChanIdxWidth-1:0]   wr_ch;
  logic [snsg_pkg::ChanIdxWidth-1:0]   rd_idx;
  logic [snsg_pkg::PeriodWidth-1:0]    period_rd;
  logic                                wr_is_vol;

  snsg_pkg::chan_state_t            cur_chan;
  snsg_pkg::chan_state_t            nxt_chan;
  logic [snsg_pkg::NoiseWidth-1:0]  noise_next;
  snsg_pkg::mix_ctrl_t              mix_ctrl;
  logic signed [snsg_pkg::SampleWidth-1:0] mixed;

  assign in_stall = (state != S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign phase_sum = {5'd0, phase} + {1'b0, tick_inc};

  // register byte decode; latch bytes carry their own channel
  assign wr_ch = write_byte[7] ? write_byte[6:5] : latched_target[2:1];
  assign wr_is_vol = write_byte[7] ? write_byte[4] : latched_target[0];

  // one read port on the period file, shared by writes and ticks
  assign rd_idx = (state == S_IDLE) ? wr_ch : ch;
  assign period_rd = tone_period[rd_idx];

  assign cur_chan.count = tick_counter[ch];
  assign cur_chan.out_bit = chan_out[ch];

  snsg_tick_unit u_tick (
    .cur        (cur_chan),
    .period     (period_rd),
    .is_noise   (ch == snsg_pkg::NoiseChan),
    .noise      (noise_shift),
    .nxt        (nxt_chan),
    .noise_next (noise_next)
  );

  always_comb begin
    mix_ctrl.clear = in_take && (kind == snsg_pkg::KindSample);
    mix_ctrl.add = (state == S_MIX);
    mix_ctrl.mul = (state == S_MUL);
  end

  snsg_mix_unit u_mix (
    .clk      (clk),
    .ctrl     (mix_ctrl),
    .level    (snsg_pkg::atten_level(attenuation[ch])),
    .positive (chan_out[ch]),
    .gain     (gain),
    .sample   (mixed)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_inc <= snsg_pkg::TickIncReset;
      gain <= snsg_pkg::GainReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        snsg_pkg::CfgTickInc: tick_inc <= cfg_data;
        snsg_pkg::CfgGain:    gain <= cfg_data[snsg_pkg::GainWidth-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch <= '0;
      ticks_left <= '0;
      phase <= '0;
      latched_target <= '0;
      noise_shift <= snsg_pkg::NoiseReset;
      chan_out <= '0;
      for (int i = 0; i < snsg_pkg::NumChannels; i++) begin
        tone_period[i] <= snsg_pkg::PeriodReset;
        tick_counter[i] <= '0;
        attenuation[i] <= snsg_pkg::AttenSilent;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (kind == snsg_pkg::KindWrite) begin
              if (write_byte[7]) begin
                latched_target <= write_byte[6:4];
              end
              if (wr_is_vol) begin
                attenuation[wr_ch] <= write_byte[3:0];
              end else if (write_byte[7]) begin
                tone_period[wr_ch] <= {period_rd[9:4], write_byte[3:0]};
              end else begin
                tone_period[wr_ch] <= {write_byte[5:0], period_rd[3:0]};
              end
            end else begin
              phase <= phase_sum[snsg_pkg::PhaseWidth-1:0];
              ticks_left <= phase_sum[snsg_pkg::TickIncWidth:snsg_pkg::PhaseWidth];
              ch <= '0;
              state <= (phase_sum[snsg_pkg::TickIncWidth:snsg_pkg::PhaseWidth] != '0)
                       ? S_TICK : S_MIX;
            end
          end
        end
        S_TICK: begin
          tick_counter[ch] <= nxt_chan.count;
          chan_out[ch] <= nxt_chan.out_bit;
          if (ch == snsg_pkg::NoiseChan) begin
            noise_shift <= noise_next;
          end
          ch <= ch + 1'b1;
          if (ch == snsg_pkg::LastChan) begin
            ticks_left <= ticks_left - 1'b1;
            if (ticks_left == 5'd1) begin
              state <= S_MIX;
            end
          end
        end
        S_MIX: begin
          ch <= ch + 1'b1;
          if (ch == snsg_pkg::LastChan) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word flag: loading a new word wins over a drain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      sample_value <= mixed;
    end
  end

  // a new word reaches the output only out of the final sequencer step
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output word loaded outside final step");

  // a sample word always starts the sequencer
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (in_take && kind == snsg_pkg::KindSample) |=> (state == S_TICK || state == S_MIX))
    else $error("sample word did not start the sequencer");

  // the mix pass always starts on the first channel
  a_mix_from_ch0: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX && $past(state) != S_MIX) |-> ch == '0)
    else $error("mix pass started off channel zero");

  // a visited channel counter is never left at zero
  a_count_reloaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |=> tick_counter[$past(ch)] != '0)
    else $error("channel counter left at zero after tick");

endmodule
